// File: design/tcfalu_pkg.sv
`default_nettype none

package tcfalu_pkg;

    localparam int WORD_BITS = 64;

    // Opcodes of the input item
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_NEG = 3'd2;
    localparam logic [2:0] OP_MUL = 3'd3;
    localparam logic [2:0] OP_DIV = 3'd4;
    localparam logic [2:0] OP_CMP = 3'd5;

    // Compare codes
    localparam logic [1:0] ORD_EQ = 2'd0;
    localparam logic [1:0] ORD_GT = 2'd1;
    localparam logic [1:0] ORD_LT = 2'd2;

    // Work the back end has to do; DIRECT items carry a finished word
    typedef enum logic [1:0] {
        KIND_ADD,
        KIND_MUL,
        KIND_DIV,
        KIND_DIRECT
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic [WORD_BITS-1:0]   op_a;
        logic [WORD_BITS-1:0]   op_b;
        logic [WORD_BITS-1:0]   direct_word;
        logic [1:0]             order;
        logic                   div_zero;
    } item_t;

endpackage

`default_nettype wire

// File: design/tcfalu_front.sv
`default_nettype none

module tcfalu_front #(
    parameter int SIG_BITS = 41,
    parameter int EXP_BITS = 23
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [2:0]                          opcode,
    input  logic [tcfalu_pkg::WORD_BITS-1:0]    operand_a,
    input  logic [tcfalu_pkg::WORD_BITS-1:0]    operand_b,
    output logic                                item_valid,
    input  logic                                item_ready,
    output tcfalu_pkg::item_t                   item
);

    localparam int WB = tcfalu_pkg::WORD_BITS;
    localparam logic [WB-1:0] SMASK = (WB'(1) << SIG_BITS) - WB'(1);
    localparam logic [WB-1:0] EMASK = (WB'(1) << EXP_BITS) - WB'(1);
    localparam logic [WB-1:0] EMAX  = EMASK >> 1;
    localparam logic [WB-1:0] WORD_MAX = (EMAX << SIG_BITS) | (SMASK >> 1);
    localparam logic [WB-1:0] WORD_MIN = (EMAX << SIG_BITS) | (WB'(1) << (SIG_BITS - 1));

    tcfalu_pkg::item_t item_reg, item_next;
    logic              valid_reg, valid_next;
    logic              load;

    logic [WB-1:0] b_sig, neg_word, xa, xb;
    logic [1:0]    order_cmp;

    assign s_ready = !valid_reg || item_ready;
    assign load    = s_valid && s_ready;

    always_comb
    begin
        b_sig    = operand_b & SMASK;
        neg_word = (((operand_b >> SIG_BITS) & EMASK) << SIG_BITS) | ((WB'(0) - b_sig) & SMASK);
        xa       = (operand_a >> SIG_BITS) & EMASK;
        xb       = (operand_b >> SIG_BITS) & EMASK;

        // raw unsigned field order, exponent first
        if (operand_a == operand_b)
            order_cmp = tcfalu_pkg::ORD_EQ;
        else if (xa > xb)
            order_cmp = tcfalu_pkg::ORD_GT;
        else if (xa < xb)
            order_cmp = tcfalu_pkg::ORD_LT;
        else if ((operand_a & SMASK) > b_sig)
            order_cmp = tcfalu_pkg::ORD_GT;
        else
            order_cmp = tcfalu_pkg::ORD_LT;

        item_next.kind        = tcfalu_pkg::KIND_DIRECT;
        item_next.op_a        = operand_a;
        item_next.op_b        = operand_b;
        item_next.direct_word = '0;
        item_next.order       = tcfalu_pkg::ORD_EQ;
        item_next.div_zero    = 1'b0;

        case (opcode)
            tcfalu_pkg::OP_ADD: item_next.kind = tcfalu_pkg::KIND_ADD;
            tcfalu_pkg::OP_SUB:
            begin
                item_next.kind = tcfalu_pkg::KIND_ADD;
                item_next.op_b = neg_word;
            end
            tcfalu_pkg::OP_NEG: item_next.direct_word = neg_word;
            tcfalu_pkg::OP_MUL: item_next.kind = tcfalu_pkg::KIND_MUL;
            tcfalu_pkg::OP_DIV:
            begin
                if (b_sig == '0)
                begin
                    item_next.div_zero    = 1'b1;
                    item_next.direct_word = operand_a[SIG_BITS-1] ? WORD_MIN : WORD_MAX;
                end
                else
                begin
                    item_next.kind = tcfalu_pkg::KIND_DIV;
                end
            end
            tcfalu_pkg::OP_CMP: item_next.order = order_cmp;
            default: ;
        endcase
    end

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (item_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// File: design/tcfalu_queue.sv
`default_nettype none

module tcfalu_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tcfalu_pkg::item_t in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output tcfalu_pkg::item_t out_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tcfalu_pkg::item_t entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push, pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= in_item;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count above depth");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + CW'(1))
        else $error("queue count missed a push");
    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> count_reg == $past(count_reg) - CW'(1))
        else $error("queue count missed a pop");
`endif

endmodule

`default_nettype wire

// File: design/tcfalu_back.sv
`default_nettype none

module tcfalu_back #(
    parameter int SIG_BITS = 41,
    parameter int EXP_BITS = 23
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    output logic                                q_ready,
    input  tcfalu_pkg::item_t                   q_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [tcfalu_pkg::WORD_BITS-1:0]    m_word,
    output logic [1:0]                          m_order,
    output logic                                m_div_zero
);

    localparam int WB  = tcfalu_pkg::WORD_BITS;
    localparam int S   = SIG_BITS;
    localparam int E   = EXP_BITS;
    localparam int W   = 2 * S;
    localparam int H   = (S + 1) / 2;
    localparam int HL  = S - H;
    localparam int SAW = $clog2(S + 1);
    localparam int LW  = $clog2(W + 1);
    localparam int SHW = LW + 1;

    typedef struct packed {
        tcfalu_pkg::kind_t  kind;
        logic [E-1:0]       ebase;
        logic               flip;
        logic [WB-1:0]      direct_word;
        logic [1:0]         order;
        logic               div_zero;
    } tail_t;

    typedef struct packed {
        tail_t              tl;
        logic [S-1:0]       sa;
        logic [S-1:0]       sb;
        logic [S-1:0]       ma;
        logic [S-1:0]       mb;
        logic               shift_a;
        logic               shift_b;
        logic [SAW-1:0]     shamt;
        logic [2*H-1:0]     p_ll;
        logic [H+HL-1:0]    p_lh;
        logic [H+HL-1:0]    p_hl;
        logic [2*HL-1:0]    p_hh;
    } x1_t;

    typedef struct packed {
        tail_t              tl;
        logic               zero_sum;
        logic [W-1:0]       t;
        logic [S-1:0]       rem;
        logic [S-1:0]       mb;
    } x2_t;

    typedef struct packed {
        tail_t              tl;
        logic               zero_sum;
        logic [W-1:0]       t;
        logic [SAW-1:0]     len_hi;
        logic [SAW-1:0]     len_lo;
    } n1_t;

    typedef struct packed {
        tail_t              tl;
        logic               zero_sum;
        logic [W-1:0]       t;
        logic [SHW-1:0]     sh;
    } n2_t;

    function automatic logic [SAW-1:0] bit_len(input logic [S-1:0] v);
        logic [SAW-1:0] n;
        n = '0;
        for (int i = 0; i < S; i++)
        begin
            if (v[i])
                n = SAW'(i + 1);
        end
        return n;
    endfunction

    // one restoring quotient bit; only divide items move
    function automatic x2_t div_step(input x2_t p);
        x2_t      q;
        logic [S:0] rs;
        logic     ge;
        q  = p;
        rs = {p.rem, p.t[W-1]};
        ge = (rs >= {1'b0, p.mb});
        if (p.tl.kind == tcfalu_pkg::KIND_DIV)
        begin
            q.t   = {p.t[W-2:0], ge};
            q.rem = ge ? S'(rs - {1'b0, p.mb}) : rs[S-1:0];
        end
        return q;
    endfunction

    logic adv;

    x1_t  x1_reg, x1_next;
    x2_t  x2_reg, x2_next;
    x2_t  d_reg [W];
    x2_t  d_next [W];
    n1_t  n1_reg, n1_next;
    n2_t  n2_reg, n2_next;

    logic x1_valid_reg, x2_valid_reg, n1_valid_reg, n2_valid_reg, out_valid_reg;
    logic [W-1:0] d_valid_reg;

    logic [WB-1:0] out_word_reg, out_word_next;
    logic [1:0]    out_order_reg, out_order_next;
    logic          out_dz_reg, out_dz_next;

    // whole back end moves together; the output register parts it from the sink
    assign adv     = !out_valid_reg || m_ready;
    assign q_ready = adv;

    // stage X1: field split, exponent compare, partial products
    always_comb
    begin
        logic [WB-1:0] a_hi, b_hi;
        logic [E-1:0]  ea, eb;
        logic          a_gt, b_gt;
        logic [E:0]    d_ab, diff;
        a_hi = q_item.op_a >> S;
        b_hi = q_item.op_b >> S;
        ea   = a_hi[E-1:0];
        eb   = b_hi[E-1:0];
        a_gt = $signed(ea) > $signed(eb);
        b_gt = $signed(eb) > $signed(ea);
        d_ab = {ea[E-1], ea} - {eb[E-1], eb};
        diff = a_gt ? d_ab : -d_ab;

        x1_next.sa      = q_item.op_a[S-1:0];
        x1_next.sb      = q_item.op_b[S-1:0];
        x1_next.ma      = x1_next.sa[S-1] ? -x1_next.sa : x1_next.sa;
        x1_next.mb      = x1_next.sb[S-1] ? -x1_next.sb : x1_next.sb;
        x1_next.shift_a = b_gt;
        x1_next.shift_b = a_gt;
        x1_next.shamt   = (diff >= (E+1)'(S)) ? SAW'(S) : diff[SAW-1:0];
        x1_next.p_ll    = (2*H)'(x1_next.ma[H-1:0]) * (2*H)'(x1_next.mb[H-1:0]);
        x1_next.p_lh    = (H+HL)'(x1_next.ma[H-1:0]) * (H+HL)'(x1_next.mb[S-1:H]);
        x1_next.p_hl    = (H+HL)'(x1_next.ma[S-1:H]) * (H+HL)'(x1_next.mb[H-1:0]);
        x1_next.p_hh    = (2*HL)'(x1_next.ma[S-1:H]) * (2*HL)'(x1_next.mb[S-1:H]);

        x1_next.tl.kind        = q_item.kind;
        x1_next.tl.direct_word = q_item.direct_word;
        x1_next.tl.order       = q_item.order;
        x1_next.tl.div_zero    = q_item.div_zero;
        x1_next.tl.flip        = 1'b0;
        x1_next.tl.ebase       = b_gt ? eb : ea;
        case (q_item.kind)
            tcfalu_pkg::KIND_MUL:
            begin
                x1_next.tl.ebase = ea + eb - E'(S - 1);
                x1_next.tl.flip  = x1_next.sa[S-1] ^ x1_next.sb[S-1];
            end
            tcfalu_pkg::KIND_DIV:
            begin
                x1_next.tl.ebase = ea - eb - E'(1);
                x1_next.tl.flip  = x1_next.sa[S-1] ^ x1_next.sb[S-1];
            end
            default: ;
        endcase
    end

    // stage X2: aligned add, product sum, divider seed
    always_comb
    begin
        logic signed [S-1:0] al_a, al_b;
        logic [S:0]          sum;
        al_a = x1_reg.sa;
        al_b = x1_reg.sb;
        if (x1_reg.shift_a)
        begin
            al_a = $signed(x1_reg.sa) >>> x1_reg.shamt;
            if (&al_a)
                al_a = '0;
        end
        if (x1_reg.shift_b)
        begin
            al_b = $signed(x1_reg.sb) >>> x1_reg.shamt;
            if (&al_b)
                al_b = '0;
        end
        sum = {al_a[S-1], al_a} + {al_b[S-1], al_b};

        x2_next.tl       = x1_reg.tl;
        x2_next.mb       = x1_reg.mb;
        x2_next.rem      = '0;
        x2_next.zero_sum = 1'b0;
        x2_next.t        = '0;
        case (x1_reg.tl.kind)
            tcfalu_pkg::KIND_ADD:
            begin
                x2_next.zero_sum = (sum == '0);
                x2_next.t        = {{(W-S-1){sum[S]}}, sum};
            end
            tcfalu_pkg::KIND_MUL:
                x2_next.t = W'(x1_reg.p_ll) + (W'(x1_reg.p_lh) << H)
                          + (W'(x1_reg.p_hl) << H) + (W'(x1_reg.p_hh) << (2 * H));
            tcfalu_pkg::KIND_DIV:
                x2_next.t = {x1_reg.ma, S'(0)};
            default: ;
        endcase
    end

    // divider stages, one quotient bit each
    always_comb
    begin
        d_next[0] = div_step(x2_reg);
        for (int i = 1; i < W; i++)
            d_next[i] = div_step(d_reg[i-1]);
    end

    // stage N1: leading-bit position per half
    always_comb
    begin
        logic [W-1:0] src;
        n1_next.tl       = d_reg[W-1].tl;
        n1_next.zero_sum = d_reg[W-1].zero_sum;
        n1_next.t        = d_reg[W-1].t;
        if (d_reg[W-1].tl.kind == tcfalu_pkg::KIND_ADD)
            src = {S'(0), d_reg[W-1].t[S] ? ~d_reg[W-1].t[S-1:0] : d_reg[W-1].t[S-1:0]};
        else
            src = d_reg[W-1].t;
        n1_next.len_hi = bit_len(src[W-1:S]);
        n1_next.len_lo = bit_len(src[S-1:0]);
    end

    // stage N2: normalizing shift amount
    always_comb
    begin
        logic [LW-1:0] len;
        len = (n1_reg.len_hi != '0) ? LW'(S) + LW'(n1_reg.len_hi) : LW'(n1_reg.len_lo);
        n2_next.tl       = n1_reg.tl;
        n2_next.zero_sum = n1_reg.zero_sum;
        n2_next.t        = n1_reg.t;
        n2_next.sh       = {1'b0, len} - SHW'(S - 1);
    end

    // output stage: shift, sign, pack
    always_comb
    begin
        logic [W-1:0]   shifted;
        logic [SHW-1:0] lamt;
        logic [S-1:0]   sig;
        logic [E-1:0]   expo;
        lamt = -n2_reg.sh;
        if ($signed(n2_reg.sh) >= 0)
            shifted = n2_reg.t >> n2_reg.sh;
        else
            shifted = n2_reg.t << lamt;
        sig = shifted[S-1:0];
        if (n2_reg.tl.flip)
            sig = -sig;
        expo = n2_reg.tl.ebase + E'($signed(n2_reg.sh));

        out_word_next  = (WB'(expo) << S) | WB'(sig);
        out_order_next = n2_reg.tl.order;
        out_dz_next    = n2_reg.tl.div_zero;
        if (n2_reg.tl.kind == tcfalu_pkg::KIND_DIRECT)
            out_word_next = n2_reg.tl.direct_word;
        else if (n2_reg.tl.kind == tcfalu_pkg::KIND_ADD && n2_reg.zero_sum)
            out_word_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_valid_reg  <= 1'b0;
            x2_valid_reg  <= 1'b0;
            d_valid_reg   <= '0;
            n1_valid_reg  <= 1'b0;
            n2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            x1_valid_reg  <= q_valid;
            x2_valid_reg  <= x1_valid_reg;
            d_valid_reg   <= {d_valid_reg[W-2:0], x2_valid_reg};
            n1_valid_reg  <= d_valid_reg[W-1];
            n2_valid_reg  <= n1_valid_reg;
            out_valid_reg <= n2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg        <= x1_next;
            x2_reg        <= x2_next;
            for (int i = 0; i < W; i++)
                d_reg[i] <= d_next[i];
            n1_reg        <= n1_next;
            n2_reg        <= n2_next;
            out_word_reg  <= out_word_next;
            out_order_reg <= out_order_next;
            out_dz_reg    <= out_dz_next;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_word     = out_word_reg;
    assign m_order    = out_order_reg;
    assign m_div_zero = out_dz_reg;

`ifndef SYNTHESIS
    a_dz_no_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_dz_reg) |-> out_order_reg == tcfalu_pkg::ORD_EQ)
        else $error("divide by zero item carries a compare code");
    a_order_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_order_reg != tcfalu_pkg::ORD_EQ) |-> out_word_reg == '0)
        else $error("compare item carries a nonzero word");
    a_pop_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && adv) |=> x1_valid_reg)
        else $error("popped item lost before the first stage");
`endif

endmodule

`default_nettype wire

// File: design/twos_complement_float_alu_unit.sv
// Two's-complement float ALU.
// Input channel s_*: one item per handshake (s_tvalid && s_tready) carrying
// an opcode in s_tuser and two packed float words in s_tdata. Each word holds
// a signed exponent above a signed significand of SIG_BITS bits.
// Output channel m_*: exactly one item per input item, in input order,
// carrying the result word, the compare code and the divide-by-zero flag.
// The result passes the front register, the queue and the back-end stages X1,
// X2, the restoring divider that spends one stage per quotient bit, N1, N2
// and the output register; every opcode runs through the same stages so order is kept.
// Throughput: one item per cycle sustained while m_tready stays high.
// The front end registers and classifies items and pushes them into a short
// queue; the back end pops the queue and runs the arithmetic pipeline.
// When m_tready is low the back end holds in place and the queue fills; the
// front end keeps taking items until the queue and its own register are full.
// Reset clears all valid bits and queue pointers; no item is in flight after.
`default_nettype none

module twos_complement_float_alu_unit #(
    parameter int SIG_BITS    = 41,
    parameter int EXP_BITS    = 23,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // [63:0] operand_a, [127:64] operand_b
    input  logic [2:0]   s_tuser,   // [2:0] opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata    // [63:0] result_word, [65:64] order,
                                    // [66] divide_by_zero, [71:67] zero
);

    logic              f_valid, f_ready;
    tcfalu_pkg::item_t f_item;
    logic              q_valid, q_ready;
    tcfalu_pkg::item_t q_item;

    logic [tcfalu_pkg::WORD_BITS-1:0] res_word;
    logic [1:0]                       res_order;
    logic                             res_dz;

    // accept and classify
    tcfalu_front #(
        .SIG_BITS (SIG_BITS),
        .EXP_BITS (EXP_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .opcode     (s_tuser),
        .operand_a  (s_tdata[63:0]),
        .operand_b  (s_tdata[127:64]),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    // decouple front and back
    tcfalu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    // execute and deliver
    tcfalu_back #(
        .SIG_BITS (SIG_BITS),
        .EXP_BITS (EXP_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_word     (res_word),
        .m_order    (res_order),
        .m_div_zero (res_dz)
    );

    assign m_tdata = {5'b0, res_dz, res_order, res_word};

endmodule

`default_nettype wire

// File: bench/tb_twos_complement_float_alu_unit.sv
`timescale 1ns / 1ps

module tb_twos_complement_float_alu_unit;

    localparam int SIG = 41;
    localparam int EXP = 23;
    localparam logic [63:0] SMASK = (64'd1 << SIG) - 64'd1;
    localparam logic [63:0] EMASK = (64'd1 << EXP) - 64'd1;
    localparam logic [63:0] TOPBIT = 64'd1 << 63;
    localparam int N_RANDOM = 400;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 120;

    // Opcodes with no operation behind them
    localparam logic [2:0] OP_RSVD_LO = 3'd6;
    localparam logic [2:0] OP_RSVD_HI = 3'd7;

    // One result item as the block reports it
    typedef struct {
        logic [63:0] word;
        logic [1:0]  ord;
        logic        dz;
    } alu_result_t;

    // One row of the directed table; fixed rows carry a hand-typed result
    typedef struct {
        logic [2:0]  op;
        logic [63:0] a;
        logic [63:0] b;
        bit          fixed;
        alu_result_t res;
    } alu_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;   // [63:0] operand_a, [127:64] operand_b
    logic [2:0]   s_tuser;   // [2:0] opcode
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;   // [63:0] result_word, [65:64] order,
                             // [66] divide_by_zero, [71:67] zero

    twos_complement_float_alu_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    alu_result_t pending_results[$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          items_sent = 0;
    int          cycles = 0;
    bit          cur_fixed = 0;
    alu_result_t cur_fixed_res;
    bit          sink_quiet = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------
    // Float arithmetic predictor
    // ---------------------------------------------------------------
    function automatic logic [63:0] sext_field(logic [63:0] x, int bits);
        logic [63:0] m;
        m = (64'd1 << bits) - 64'd1;
        x = x & m;
        if (x[bits-1])
            x = x | ~m;
        return x;
    endfunction

    function automatic logic [63:0] pack_word(logic [63:0] e, logic [63:0] s);
        return ((e & EMASK) << SIG) | (s & SMASK);
    endfunction

    function automatic bit signed_gt(logic [63:0] a, logic [63:0] b);
        return (a ^ TOPBIT) > (b ^ TOPBIT);
    endfunction

    function automatic int bit_length(logic [127:0] x);
        int n;
        n = 0;
        for (int i = 0; i < 128; i++)
            if (x[i])
                n = i + 1;
        return n;
    endfunction

    function automatic logic [63:0] exp_of(logic [63:0] w);
        return sext_field((w >> SIG) & EMASK, EXP);
    endfunction

    // Arithmetic shift for alignment; an all-ones remnant collapses to zero
    function automatic logic [63:0] align_sig(logic [63:0] s, logic [63:0] d);
        logic [63:0] r;
        bit neg;
        neg = s[63];
        if (d >= 64)
            r = neg ? ~64'd0 : 64'd0;
        else
            r = neg ? ~((~s) >> d) : (s >> d);
        if (neg && ((r & SMASK) == SMASK))
            r = 64'd0;
        return r;
    endfunction

    function automatic logic [63:0] float_add(logic [63:0] a, logic [63:0] b);
        logic [63:0] ea, eb, sa, sb, e, sum;
        int len, sh;
        ea = exp_of(a);
        eb = exp_of(b);
        sa = sext_field(a, SIG);
        sb = sext_field(b, SIG);
        e = ea;
        if (signed_gt(ea, eb))
            sb = align_sig(sb, ea - eb);
        else if (signed_gt(eb, ea))
        begin
            sa = align_sig(sa, eb - ea);
            e = eb;
        end
        sum = sa + sb;
        if (sum == 64'd0)
            return 64'd0;
        if (sum[63])
            len = bit_length({64'd0, ~sum & SMASK});
        else
            len = bit_length({64'd0, sum & SMASK});
        sh = len - (SIG - 1);
        if (sh > 0)
            sum = sum >> sh;
        else if (sh < 0)
            sum = sum << (-sh);
        e = e + longint'(sh);
        return pack_word(e, sum);
    endfunction

    function automatic logic [63:0] float_neg(logic [63:0] b);
        return pack_word(b >> SIG, (64'd0 - (b & SMASK)) & SMASK);
    endfunction

    function automatic logic [63:0] sig_magnitude(logic [63:0] w, output bit neg);
        logic [63:0] s;
        s = w & SMASK;
        neg = s[SIG-1];
        return neg ? ((64'd0 - s) & SMASK) : s;
    endfunction

    // Renormalize a double-width magnitude, adjust exponent, restore sign
    function automatic logic [63:0] renorm_wide(logic [127:0] t, logic [63:0] e,
                                                int adj, bit flip);
        int sh;
        logic [63:0] r;
        logic [127:0] tmp;
        sh = bit_length(t) - (SIG - 1);
        r = t[63:0] & SMASK;
        if (sh > 0)
        begin
            tmp = t >> sh;
            r = tmp[63:0];
        end
        else if (sh < 0)
        begin
            tmp = t << (-sh);
            r = tmp[63:0];
        end
        e = e + longint'(sh + adj);
        if (flip)
            r = 64'd0 - r;
        return pack_word(e, r);
    endfunction

    function automatic alu_result_t predict_result(logic [2:0] op, logic [63:0] a,
                                                   logic [63:0] b);
        alu_result_t r;
        bit na, nb;
        logic [63:0] ma, mb;
        logic [127:0] num, q;
        r.word = 64'd0;
        r.ord = tcfalu_pkg::ORD_EQ;
        r.dz = 1'b0;
        case (op)
            tcfalu_pkg::OP_ADD: r.word = float_add(a, b);
            tcfalu_pkg::OP_SUB: r.word = float_add(a, float_neg(b));
            tcfalu_pkg::OP_NEG: r.word = float_neg(b);
            tcfalu_pkg::OP_MUL:
            begin
                ma = sig_magnitude(a, na);
                mb = sig_magnitude(b, nb);
                r.word = renorm_wide({64'd0, ma} * {64'd0, mb}, exp_of(a) + exp_of(b),
                                     1 - SIG, na != nb);
            end
            tcfalu_pkg::OP_DIV:
            begin
                ma = sig_magnitude(a, na);
                mb = sig_magnitude(b, nb);
                if (mb == 64'd0)
                begin
                    r.dz = 1'b1;
                    r.word = na ? pack_word(EMASK >> 1, 64'd1 << (SIG - 1))
                                : pack_word(EMASK >> 1, SMASK >> 1);
                end
                else
                begin
                    num = {64'd0, ma} << SIG;
                    q = num / {64'd0, mb};
                    r.word = renorm_wide(q, exp_of(a) - exp_of(b), -1, na != nb);
                end
            end
            tcfalu_pkg::OP_CMP:
            begin
                if (a == b)
                    r.ord = tcfalu_pkg::ORD_EQ;
                else if (((a >> SIG) & EMASK) > ((b >> SIG) & EMASK))
                    r.ord = tcfalu_pkg::ORD_GT;
                else if (((a >> SIG) & EMASK) < ((b >> SIG) & EMASK))
                    r.ord = tcfalu_pkg::ORD_LT;
                else
                    r.ord = ((a & SMASK) > (b & SMASK)) ? tcfalu_pkg::ORD_GT
                                                        : tcfalu_pkg::ORD_LT;
            end
            default: ;
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at result %0d: %s got %h expected %h",
                 results_seen, what, got, want);
        mismatches++;
    endtask

    // Sample both handshakes at the rising edge; queue on input, compare on output
    always @(posedge clk)
    begin
        alu_result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                if (cur_fixed)
                    pending_results.push_back(cur_fixed_res);
                else
                    pending_results.push_back(predict_result(s_tuser, s_tdata[63:0],
                                                             s_tdata[127:64]));
                items_sent++;
            end
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected item", {56'd0, m_tdata[71:64]}, 64'd0);
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tdata[63:0] !== want.word)
                        report_mismatch("result_word", m_tdata[63:0], want.word);
                    if (m_tdata[65:64] !== want.ord)
                        report_mismatch("order", 64'(m_tdata[65:64]), 64'(want.ord));
                    if (m_tdata[66] !== want.dz)
                        report_mismatch("divide_by_zero", 64'(m_tdata[66]), 64'(want.dz));
                    if (m_tdata[71:67] !== 5'd0)
                        report_mismatch("padding", 64'(m_tdata[71:67]), 64'd0);
                end
                results_seen++;
            end
        end
    end

    // Hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     pending_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    // Mostly no gap, sometimes a short gap, rarely a long hold-off
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] random_sig();
        logic [63:0] s;
        case ($urandom_range(0, 9))
            0: s = 64'd0;
            1: s = SMASK;                       // minus one
            2: s = 64'd1 << (SIG - 1);          // most negative
            3: s = SMASK >> 1;                  // most positive
            4: s = $urandom_range(0, 255);
            5: s = SMASK - $urandom_range(0, 255);
            default: s = {$urandom, $urandom};
        endcase
        return s & SMASK;
    endfunction

    function automatic logic [63:0] random_exp(logic [63:0] near);
        logic [63:0] e;
        case ($urandom_range(0, 9))
            0: e = EMASK >> 1;                  // largest positive
            1: e = (EMASK >> 1) + 64'd1;        // most negative
            2: e = near + 64'($urandom_range(0, 3)) - 64'd1;
            3: e = near + 64'($urandom_range(60, 70));
            4: e = near - 64'($urandom_range(0, 45));
            5: e = near + 64'($urandom_range(0, 45));
            6: e = 64'd0 - 64'($urandom_range(0, 8));
            default: e = $urandom;
        endcase
        return e & EMASK;
    endfunction

    // Drive one item at the falling edge and hold it until accepted
    task automatic send_item(logic [2:0] op, logic [63:0] a, logic [63:0] b,
                             bit fixed, alu_result_t res);
        bit taken;
        s_tuser = op;
        s_tdata = {b, a};
        cur_fixed = fixed;
        cur_fixed_res = res;
        s_tvalid = 1'b1;
        taken = 0;
        while (!taken)
        begin
            @(posedge clk);
            taken = s_tready;
            @(negedge clk);
        end
    endtask

    task automatic idle_source(int n);
        if (n > 0)
        begin
            s_tvalid = 1'b0;
            s_tdata = {$urandom, $urandom, $urandom, $urandom};
            repeat (n) @(negedge clk);
        end
    endtask

    // Receiver: random stalls, with quiet stretches that never stall
    initial
    begin
        int stall;
        stall = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready = 1'b0;
                stall--;
            end
            else
            begin
                m_tready = 1'b1;
                if (!sink_quiet && $urandom_range(0, 3) == 0)
                    stall = random_gap();
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    alu_row_t directed_rows[$];

    task automatic add_row(logic [2:0] op, logic [63:0] a, logic [63:0] b, bit fixed,
                           logic [63:0] word, logic [1:0] ord, logic dz);
        alu_row_t row;
        row.op = op;
        row.a = a;
        row.b = b;
        row.fixed = fixed;
        row.res.word = word;
        row.res.ord = ord;
        row.res.dz = dz;
        directed_rows.push_back(row);
    endtask

    initial
    begin
        logic [63:0] max_word, min_word, a, b, ea;
        logic [2:0] op;
        alu_result_t none;
        max_word = {23'h3fffff, 41'h0ffffffffff};
        min_word = {23'h3fffff, 41'h10000000000};
        none = '{64'd0, tcfalu_pkg::ORD_EQ, 1'b0};

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = tcfalu_pkg::OP_ADD;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table: fixed results where they follow directly
        add_row(tcfalu_pkg::OP_ADD, 64'd0, 64'd0, 1, 64'd0, tcfalu_pkg::ORD_EQ, 0);
        add_row(tcfalu_pkg::OP_NEG, 64'd0, 64'd0, 1, 64'd0, tcfalu_pkg::ORD_EQ, 0);
        add_row(tcfalu_pkg::OP_DIV, 64'h123, 64'd0, 1, max_word, tcfalu_pkg::ORD_EQ, 1);
        add_row(tcfalu_pkg::OP_DIV, {23'd5, 41'h1ffffffffff}, {23'd9, 41'd0}, 1, min_word,
                tcfalu_pkg::ORD_EQ, 1);
        add_row(tcfalu_pkg::OP_CMP, ~64'd0, ~64'd0, 1, 64'd0, tcfalu_pkg::ORD_EQ, 0);
        add_row(tcfalu_pkg::OP_CMP, ~64'd0, 64'd0, 1, 64'd0, tcfalu_pkg::ORD_GT, 0);
        add_row(tcfalu_pkg::OP_CMP, 64'd0, ~64'd0, 1, 64'd0, tcfalu_pkg::ORD_LT, 0);
        add_row(OP_RSVD_LO, ~64'd0, ~64'd0, 1, 64'd0, tcfalu_pkg::ORD_EQ, 0);
        add_row(OP_RSVD_HI, 64'h5555, ~64'd0, 1, 64'd0, tcfalu_pkg::ORD_EQ, 0);
        add_row(tcfalu_pkg::OP_ADD, max_word, max_word, 0, 0, tcfalu_pkg::ORD_EQ, 0);
        add_row(tcfalu_pkg::OP_ADD, min_word, min_word, 0, 0, tcfalu_pkg::ORD_EQ, 0);
        add_row(tcfalu_pkg::OP_ADD, {23'd100, 41'h1ffffffffff}, {23'd0, 41'h1ffffffffff},
                0, 0, tcfalu_pkg::ORD_EQ, 0);
        add_row(tcfalu_pkg::OP_ADD, {23'd200, 41'h0ffff}, {23'd100, 41'h0ffff},
                0, 0, tcfalu_pkg::ORD_EQ, 0);
        add_row(tcfalu_pkg::OP_ADD, {23'd10, 41'h12345}, {23'd10, 41'h1ffffffedcb},
                0, 0, tcfalu_pkg::ORD_EQ, 0);
        add_row(tcfalu_pkg::OP_SUB, {23'd3, 41'h0abcdef}, {23'd3, 41'h0abcdef},
                0, 0, tcfalu_pkg::ORD_EQ, 0);
        add_row(tcfalu_pkg::OP_SUB, max_word, min_word, 0, 0, tcfalu_pkg::ORD_EQ, 0);
        add_row(tcfalu_pkg::OP_NEG, 64'd0, min_word, 0, 0, tcfalu_pkg::ORD_EQ, 0);
        add_row(tcfalu_pkg::OP_NEG, 64'd0, ~64'd0, 0, 0, tcfalu_pkg::ORD_EQ, 0);
        add_row(tcfalu_pkg::OP_MUL, max_word, max_word, 0, 0, tcfalu_pkg::ORD_EQ, 0);
        add_row(tcfalu_pkg::OP_MUL, min_word, min_word, 0, 0, tcfalu_pkg::ORD_EQ, 0);
        add_row(tcfalu_pkg::OP_MUL, {23'd7, 41'd0}, max_word, 0, 0, tcfalu_pkg::ORD_EQ, 0);
        add_row(tcfalu_pkg::OP_DIV, max_word, min_word, 0, 0, tcfalu_pkg::ORD_EQ, 0);
        add_row(tcfalu_pkg::OP_DIV, {23'h400000, 41'd1}, max_word, 0, 0,
                tcfalu_pkg::ORD_EQ, 0);
        add_row(tcfalu_pkg::OP_CMP, {23'd4, 41'd9}, {23'd4, 41'd3}, 0, 0,
                tcfalu_pkg::ORD_EQ, 0);

        foreach (directed_rows[i])
        begin
            send_item(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                      directed_rows[i].fixed, directed_rows[i].res);
            idle_source(random_gap());
        end

        // Random part: related exponents so alignment paths are hit often
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n % 80 == 0)
                sink_quiet = ($urandom_range(0, 2) == 0);
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI))
                                               : 3'($urandom_range(0, 5));
            ea = $urandom & EMASK;
            a = pack_word(random_exp(ea), random_sig());
            b = pack_word(random_exp(a >> SIG), random_sig());
            if (op == tcfalu_pkg::OP_CMP && $urandom_range(0, 3) == 0)
                b = a;
            if ($urandom_range(0, 15) == 0)
                a = {$urandom, $urandom};
            send_item(op, a, b, 0, none);
            if (!sink_quiet)
                idle_source(random_gap());
        end
        s_tvalid = 1'b0;

        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d items: all opcodes, divide by zero, alignment and", items_sent);
        $display("renormalization extremes; %0d results checked", results_seen);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
